// ===== sv/rsmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Resampler package
// Phase format, run limits and the shared interpolation unit's control type.
// ----------------------------------------------------------------------------
`default_nettype none

package rsmp_pkg;

  localparam int unsigned PhaseFracBits = 16;
  localparam int unsigned PhaseW        = PhaseFracBits + 1;
  localparam int unsigned MaxRun        = 64;
  localparam int unsigned RunCntW       = $clog2(MaxRun + 1);

  localparam logic [PhaseFracBits-1:0] MinStep   = PhaseFracBits'(1024);
  localparam logic [PhaseFracBits-1:0] ResetStep = PhaseFracBits'(44685);
  localparam logic [RunCntW-1:0]       RunLimit  = RunCntW'(MaxRun);

  typedef enum logic {
    CH_LEFT,
    CH_RIGHT
  } chan_e;

  typedef struct packed {
    logic  valid;
    chan_e chan;
  } lerp_ctl_t;

endpackage

`default_nettype wire

// ===== sv/rsmp_lerp.sv =====
// ----------------------------------------------------------------------------
// Shared interpolation unit
// Four-stage pipeline computing a + frac * (b - a), truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmp_lerp #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire rsmp_pkg::lerp_ctl_t         req_i,
  input  wire logic [SAMPLE_WIDTH-1:0]     a_i,
  input  wire logic [SAMPLE_WIDTH-1:0]     b_i,
  input  wire logic [rsmp_pkg::PhaseFracBits-1:0] frac_i,
  output rsmp_pkg::lerp_ctl_t              rsp_o,
  output logic [SAMPLE_WIDTH-1:0]          res_o
);

  localparam int unsigned Pf   = rsmp_pkg::PhaseFracBits;
  localparam int unsigned NumW = SAMPLE_WIDTH + Pf + 2;

  rsmp_pkg::lerp_ctl_t s1_ctl_q, s2_ctl_q, s3_ctl_q, s4_ctl_q;

  logic signed [SAMPLE_WIDTH:0]   s1_diff_q, s1_diff_d;
  logic        [SAMPLE_WIDTH-1:0] s1_base_q, s2_base_q;
  logic        [Pf-1:0]           s1_frac_q;
  logic signed [NumW-1:0]         s2_prod_q, s2_prod_d;
  logic signed [NumW-1:0]         s3_num_q, s3_num_d;
  logic        [NumW-1:0]         bias;
  logic        [NumW-1:0]         biased;
  logic        [SAMPLE_WIDTH-1:0] s4_res_q;

  assign s1_diff_d = $signed({b_i[SAMPLE_WIDTH-1], b_i})
                   - $signed({a_i[SAMPLE_WIDTH-1], a_i});
  assign s2_prod_d = NumW'(s1_diff_q) * NumW'($signed({1'b0, s1_frac_q}));
  assign s3_num_d  = s2_prod_q
                   + $signed({{2{s2_base_q[SAMPLE_WIDTH-1]}}, s2_base_q, {Pf{1'b0}}});

  // A negative sum is biased so that the arithmetic shift rounds toward zero.
  assign bias   = s3_num_q[NumW-1] ? {{(NumW-Pf){1'b0}}, {Pf{1'b1}}} : '0;
  assign biased = s3_num_q + bias;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
      s4_ctl_q <= '0;
    end else begin
      s1_ctl_q <= req_i;
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
      s4_ctl_q <= s3_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_diff_q <= s1_diff_d;
    s1_base_q <= a_i;
    s1_frac_q <= frac_i;
    s2_prod_q <= s2_prod_d;
    s2_base_q <= s1_base_q;
    s3_num_q  <= s3_num_d;
    s4_res_q  <= biased[Pf+SAMPLE_WIDTH-1:Pf];
  end

  assign rsp_o = s4_ctl_q;
  assign res_o = s4_res_q;

endmodule

`default_nettype wire

// ===== sv/stereo_linear_resampler.sv =====
// ----------------------------------------------------------------------------
// Stereo linear resampler
// Emits output-rate stereo frames interpolated between successive source frames.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                    Direction
// input     in_valid_i / in_ready_o, left_in_i, right_in_i   request in
// output    out_valid_o / out_ready_i, left_out_o, right_out_o, last_of_run_o
// config    rate_step_we_i, rate_step_i                write only
//
// One multiplier is shared by both channels and its four-stage pipeline is
// waited out for every output frame. Each request also passes through an
// acceptance state and an end-of-run check. The input is not ready while a
// request is being worked on. A stalled output holds the sequencer before the
// next frame is issued. Reset clears the previous frame and phase and restores
// the default step.
`default_nettype none

module stereo_linear_resampler #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     rate_step_we_i,
  input  wire logic [rsmp_pkg::PhaseFracBits-1:0] rate_step_i,
  input  wire                                     in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [SAMPLE_WIDTH-1:0]            left_in_i,
  input  wire logic [SAMPLE_WIDTH-1:0]            right_in_i,
  output logic                                    out_valid_o,
  input  wire                                     out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]                 left_out_o,
  output logic [SAMPLE_WIDTH-1:0]                 right_out_o,
  output logic                                    last_of_run_o
);

  localparam int unsigned Pf = rsmp_pkg::PhaseFracBits;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_ISSUE_L = 3'd2;
  localparam logic [2:0] ST_ISSUE_R = 3'd3;
  localparam logic [2:0] ST_WAIT    = 3'd4;

  logic [2:0]                        state_q, state_d;
  logic [Pf-1:0]                     rate_step_q;
  logic [Pf-1:0]                     step_eff;
  logic [rsmp_pkg::PhaseW-1:0]       phase_q, phase_d;
  logic [rsmp_pkg::PhaseW-1:0]       phase_next;
  logic [rsmp_pkg::RunCntW-1:0]      cnt_q, cnt_d;
  logic [rsmp_pkg::RunCntW-1:0]      cnt_inc;
  logic                              last_q, last_d;
  logic [SAMPLE_WIDTH-1:0]           prev_l_q, prev_r_q, cur_l_q, cur_r_q;
  logic [SAMPLE_WIDTH-1:0]           hold_l_q;
  logic                              out_valid_q;
  logic [SAMPLE_WIDTH-1:0]           out_l_q, out_r_q;
  logic                              out_last_q;
  logic                              run_more;
  logic                              out_free;
  logic                              in_fire;
  logic                              rsp_right;
  rsmp_pkg::lerp_ctl_t               lerp_req, lerp_rsp;
  logic [SAMPLE_WIDTH-1:0]           lerp_a, lerp_b, lerp_res;

  assign step_eff   = (rate_step_q < rsmp_pkg::MinStep) ? rsmp_pkg::MinStep : rate_step_q;
  assign phase_next = phase_q + {1'b0, step_eff};
  assign cnt_inc    = cnt_q + 1'b1;
  assign run_more   = !phase_q[Pf] && (cnt_q != rsmp_pkg::RunLimit);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign rsp_right  = lerp_rsp.valid && (lerp_rsp.chan == rsmp_pkg::CH_RIGHT);

  assign lerp_req.valid = (state_q == ST_ISSUE_L) || (state_q == ST_ISSUE_R);
  assign lerp_req.chan  = (state_q == ST_ISSUE_L) ? rsmp_pkg::CH_LEFT : rsmp_pkg::CH_RIGHT;
  assign lerp_a         = (state_q == ST_ISSUE_L) ? prev_l_q : prev_r_q;
  assign lerp_b         = (state_q == ST_ISSUE_L) ? cur_l_q : cur_r_q;

  rsmp_lerp #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_lerp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (lerp_req),
    .a_i   (lerp_a),
    .b_i   (lerp_b),
    .frac_i(phase_q[Pf-1:0]),
    .rsp_o (lerp_rsp),
    .res_o (lerp_res)
  );

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d   = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (run_more) begin
          if (out_free) begin
            state_d = ST_ISSUE_L;
          end
        end else begin
          phase_d = phase_q[Pf] ? {1'b0, phase_q[Pf-1:0]} : '0;
          state_d = ST_IDLE;
        end
      end
      ST_ISSUE_L: begin
        state_d = ST_ISSUE_R;
      end
      ST_ISSUE_R: begin
        phase_d = phase_next;
        cnt_d   = cnt_inc;
        last_d  = phase_next[Pf] || (cnt_inc == rsmp_pkg::RunLimit);
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (rsp_right) begin
          state_d = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_step_q <= rsmp_pkg::ResetStep;
      phase_q     <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      if (rate_step_we_i) begin
        rate_step_q <= rate_step_i;
      end
      if ((state_q == ST_CHECK) && !run_more) begin
        prev_l_q <= cur_l_q;
        prev_r_q <= cur_r_q;
      end
      if (rsp_right) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur_l_q <= left_in_i;
      cur_r_q <= right_in_i;
    end
    if (lerp_rsp.valid && (lerp_rsp.chan == rsmp_pkg::CH_LEFT)) begin
      hold_l_q <= lerp_res;
    end
    if (rsp_right) begin
      out_l_q    <= hold_l_q;
      out_r_q    <= lerp_res;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_out_o    = out_l_q;
  assign right_out_o   = out_r_q;
  assign last_of_run_o = out_last_q;

endmodule

`default_nettype wire

// ===== tb/tb_stereo_linear_resampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo linear resampler testbench
// Drives stereo source frames and step settings into the resampler and checks
// every interpolated output frame, and its end-of-run flag, against a
// cycle-free model of the phase accumulator. A short list of directed
// requests comes first, followed by random requests under several patterns
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb_stereo_linear_resampler;

  localparam int unsigned SampleW = 16;
  localparam logic [rsmp_pkg::PhaseW-1:0] PhaseOne =
    rsmp_pkg::PhaseW'(1) << rsmp_pkg::PhaseFracBits;

  typedef struct packed {
    logic [SampleW-1:0] left;
    logic [SampleW-1:0] right;
    logic               last_run;
  } out_frame_t;

  typedef enum logic {
    ROW_FRAME,
    ROW_STEP
  } row_kind_e;

  typedef struct packed {
    row_kind_e                          kind;
    logic [rsmp_pkg::PhaseFracBits-1:0] step;
    logic [SampleW-1:0]                 left;
    logic [SampleW-1:0]                 right;
    logic                               pinned;
    logic [SampleW-1:0]                 pin_left;
    logic [SampleW-1:0]                 pin_right;
  } dir_row_t;

  // A pinned row repeats the previous frame, so every frame of its run is that frame.
  localparam dir_row_t DirRows [25] = '{
    '{ROW_FRAME, 16'd0,     16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
    '{ROW_FRAME, 16'd0,     16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
    '{ROW_FRAME, 16'd0,     16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'hFFFF, 16'h0001, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'h0001, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'hFFFD, 16'h0003, 1'b0, 16'h0000, 16'h0000},
    '{ROW_STEP,  16'd0,     16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'd12345, 16'hCFC7, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_STEP,  16'd1023,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'd100,  16'hFF9C, 1'b0, 16'h0000, 16'h0000},
    '{ROW_STEP,  16'd1024,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF, 16'h7FFF},
    '{ROW_STEP,  16'hFFFF,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000},
    '{ROW_STEP,  16'd32768, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'h0007, 16'hFFF9, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'h0007, 16'hFFF9, 1'b1, 16'h0007, 16'hFFF9},
    '{ROW_STEP,  rsmp_pkg::ResetStep, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, 16'd0,     16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000}
  };

  localparam int SendIdlePct [4] = '{0, 67, 0, 38};
  localparam int RecvStallPct [4] = '{0, 0, 67, 38};

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               rate_step_we_i = 1'b0;
  logic [rsmp_pkg::PhaseFracBits-1:0] rate_step_i = '0;
  logic                               in_valid_i = 1'b0;
  logic                               in_ready_o;
  logic [SampleW-1:0]                 left_in_i = '0;
  logic [SampleW-1:0]                 right_in_i = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic [SampleW-1:0]                 left_out_o;
  logic [SampleW-1:0]                 right_out_o;
  logic                               last_of_run_o;

  logic [rsmp_pkg::PhaseFracBits-1:0] step_now = rsmp_pkg::ResetStep;
  logic [SampleW-1:0]                 prev_left = '0;
  logic [SampleW-1:0]                 prev_right = '0;
  logic [rsmp_pkg::PhaseW-1:0]        phase_acc = '0;

  logic                               pin_on = 1'b0;
  logic [SampleW-1:0]                 pin_left = '0;
  logic [SampleW-1:0]                 pin_right = '0;

  out_frame_t frames_due[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int requests_taken = 0;
  int frames_checked = 0;
  int step_writes = 0;
  int longest_run = 0;

  stereo_linear_resampler #(
    .SAMPLE_WIDTH(SampleW)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rate_step_we_i(rate_step_we_i),
    .rate_step_i   (rate_step_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .left_in_i     (left_in_i),
    .right_in_i    (right_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The product is formed exactly and then truncated toward zero.
  function automatic logic [SampleW-1:0] blend(input logic signed [SampleW-1:0] a,
                                               input logic signed [SampleW-1:0] b,
                                               input logic [rsmp_pkg::PhaseFracBits-1:0] frac);
    longint acc;
    acc = (longint'(a) <<< rsmp_pkg::PhaseFracBits)
        + (longint'(b) - longint'(a)) * longint'($signed({1'b0, frac}));
    if (acc < 0) begin
      return SampleW'(-((-acc) >>> rsmp_pkg::PhaseFracBits));
    end
    return SampleW'(acc >>> rsmp_pkg::PhaseFracBits);
  endfunction

  task automatic interpolate_run(input logic [SampleW-1:0] cur_left,
                                 input logic [SampleW-1:0] cur_right);
    logic [rsmp_pkg::PhaseFracBits-1:0] stride;
    logic [rsmp_pkg::PhaseFracBits-1:0] frac;
    out_frame_t                         fr;
    int                                 n;
    stride = (step_now < rsmp_pkg::MinStep) ? rsmp_pkg::MinStep : step_now;
    n = 0;
    while (phase_acc < PhaseOne && n < rsmp_pkg::MaxRun) begin
      frac = phase_acc[rsmp_pkg::PhaseFracBits-1:0];
      fr.left  = pin_on ? pin_left : blend(prev_left, cur_left, frac);
      fr.right = pin_on ? pin_right : blend(prev_right, cur_right, frac);
      phase_acc = phase_acc + rsmp_pkg::PhaseW'(stride);
      n++;
      fr.last_run = !(phase_acc < PhaseOne && n < rsmp_pkg::MaxRun);
      frames_due.push_back(fr);
    end
    phase_acc = (phase_acc >= PhaseOne) ? phase_acc - PhaseOne : '0;
    prev_left = cur_left;
    prev_right = cur_right;
    if (n > longest_run) begin
      longest_run = n;
    end
  endtask

  always @(posedge clk_i) begin
    out_frame_t got;
    out_frame_t want;
    if (rst_ni) begin
      if (rate_step_we_i) begin
        step_now = rate_step_i;
        step_writes++;
      end
      if (in_valid_i && in_ready_o) begin
        interpolate_run(left_in_i, right_in_i);
        requests_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        got = '{left_out_o, right_out_o, last_of_run_o};
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected frame: left %0d right %0d last %0b", $time,
                   $signed(got.left), $signed(got.right), got.last_run);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          frames_checked++;
          if (got !== want) begin
            $display("%0t: expected left %0d right %0d last %0b, got left %0d right %0d last %0b",
                     $time, $signed(want.left), $signed(want.right), want.last_run,
                     $signed(got.left), $signed(got.right), got.last_run);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_frame(input logic [SampleW-1:0] l, input logic [SampleW-1:0] r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_in_i <= l;
    right_in_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_step(input logic [rsmp_pkg::PhaseFracBits-1:0] value);
    settle();
    repeat (16) @(posedge clk_i);
    rate_step_we_i <= 1'b1;
    rate_step_i <= value;
    @(posedge clk_i);
    rate_step_we_i <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] sample_value();
    if ($urandom_range(3) != 0) begin
      return SampleW'($urandom);
    end
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  initial begin
    logic [rsmp_pkg::PhaseFracBits-1:0] st;
    logic [SampleW-1:0]                 l;
    logic [SampleW-1:0]                 r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DirRows); i++) begin
      if (DirRows[i].kind == ROW_STEP) begin
        load_step(DirRows[i].step);
      end else begin
        pin_on <= DirRows[i].pinned;
        pin_left <= DirRows[i].pin_left;
        pin_right <= DirRows[i].pin_right;
        send_frame(DirRows[i].left, DirRows[i].right);
      end
    end
    pin_on <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SendIdlePct[ph];
      stall_pct = RecvStallPct[ph];
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(4))
          0: st = rsmp_pkg::PhaseFracBits'($urandom_range(1023));
          1: st = rsmp_pkg::MinStep;
          2: st = '1;
          default: st = rsmp_pkg::PhaseFracBits'($urandom_range(65535, 1024));
        endcase
        load_step(st);
        repeat (13) begin
          if ($urandom_range(9) == 0) begin
            settle();
          end
          l = sample_value();
          r = sample_value();
          send_frame(l, r);
        end
      end
    end

    settle();
    repeat (30) @(posedge clk_i);
    $display("Run covered %0d source frames, %0d checked output frames and %0d step writes.",
             requests_taken, frames_checked, step_writes);
    $display("Longest run from one source frame: %0d output frames.", longest_run);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("** stereo_linear_resampler: PASSED **");
    end else begin
      $display("** stereo_linear_resampler: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d frames outstanding", $time, frames_due.size());
    $display("** stereo_linear_resampler: FAILED **");
    $finish;
  end

endmodule
